[design/hts_pkg.sv]
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types and constants for the hash table insert/search block.
// ----------------------------------------------------------------------------
package hts_pkg;

   localparam int KEY_W          = 31;
   localparam int SLOT_W         = 5;
   localparam int CNT_W          = 16;
   localparam int DEF_TABLE_SIZE = 32;

   typedef enum logic [1:0] {
      STAT_STORED = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_FOUND  = 2'd2,
      STAT_MISS   = 2'd3
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_SEARCH = 1'b1
   } opcode_type;

   // which slot index a write or a result refers to
   typedef enum logic [1:0] {
      SEL_HOME = 2'd0,
      SEL_NEXT = 2'd1,
      SEL_SCAN = 2'd2,
      SEL_ZERO = 2'd3
   } slot_sel_type;

   typedef struct packed {
      logic         clr_step;
      logic         load;
      logic         hash_step;
      logic         rd_home;
      logic         rd_next;
      logic         scan_init;
      logic         scan_step;
      logic         bump;
      logic         set_res;
      logic         write;
      slot_sel_type sel;
      status_type   res_status;
      logic         out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic hash_last;
      logic search;
      logic hit;
      logic scan_hit;
      logic scan_miss;
   } sts_type;

endpackage

[design/hts_ram.sv]
// ----------------------------------------------------------------------------
// hts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hts_ram #(
   parameter int WIDTH = hts_pkg::KEY_W + 1,
   parameter int DEPTH = hts_pkg::DEF_TABLE_SIZE,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hts_dpath.sv]
// ----------------------------------------------------------------------------
// hts_dpath
// Datapath: key-modulo unit, slot RAM, scan pointers, collision counter
// and result registers.
// ----------------------------------------------------------------------------
module hts_dpath #(
   parameter int TABLE_SIZE = hts_pkg::DEF_TABLE_SIZE
) (
   input  logic                         clock,
   input  logic                         reset,
   input  hts_pkg::cmd_type             cmd,
   output hts_pkg::sts_type             sts,
   input  logic                         req_opcode,
   input  logic [hts_pkg::KEY_W-1:0]    req_key,
   output logic [1:0]                   rsp_status,
   output logic [hts_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [hts_pkg::CNT_W-1:0]    rsp_collision_count
);

   localparam int KEY_W  = hts_pkg::KEY_W;
   localparam int SLOT_W = hts_pkg::SLOT_W;
   localparam int CNT_W  = hts_pkg::CNT_W;
   localparam int IDX_W  = $clog2(TABLE_SIZE);
   localparam int PROD_W = KEY_W + 32;
   localparam logic [IDX_W:0]   SIZE_V    = (IDX_W+1)'(TABLE_SIZE);
   localparam logic [IDX_W-1:0] SIZE_LO   = IDX_W'(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;
   // 2^(KEY_W+IDX_W) / TABLE_SIZE rounded up: the quotient it gives is exact
   // for every KEY_W-bit key
   localparam logic [63:0]      RECIP_V   =
      ((64'd1 << (KEY_W + IDX_W)) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [31:0]      RECIP     = RECIP_V[31:0];

   logic                 op_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 hcnt_ff;
   logic [IDX_W-1:0]     rem_ff;
   logic [IDX_W-1:0]     clr_ptr_ff;
   logic [CNT_W-1:0]     coll_ff;
   logic [IDX_W:0]       scan_ptr_ff;
   logic [IDX_W-1:0]     chk_idx_ff;
   logic                 chk_vld_ff;
   hts_pkg::status_type  res_status_ff;
   logic [IDX_W-1:0]     res_slot_ff;
   logic [1:0]           rsp_status_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [CNT_W-1:0]     rsp_coll_ff;

   logic [IDX_W-1:0]     quo_lo;
   logic [IDX_W-1:0]     quo_mul;
   logic [IDX_W-1:0]     rem_in;
   logic [IDX_W-1:0]     next_idx;
   logic [IDX_W-1:0]     sel_idx;
   logic                 scan_issue;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [KEY_W:0]       ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [KEY_W:0]       ram_rd_data;
   logic                 slot_vld;
   logic                 hit;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   // key mod TABLE_SIZE: quotient by reciprocal multiply, then key minus
   // quotient times size; the remainder fits the low IDX_W bits
   assign quo_lo  = prod_ff[KEY_W+IDX_W +: IDX_W];
   assign quo_mul = quo_lo * SIZE_LO;
   assign rem_in  = key_ff[IDX_W-1:0] - quo_mul;

   assign next_idx   = (rem_ff == LAST_IDX) ? '0 : rem_ff + 1'b1;
   assign scan_issue = cmd.scan_step && (scan_ptr_ff < SIZE_V);

   always_comb begin
      case (cmd.sel)
         hts_pkg::SEL_HOME: sel_idx = rem_ff;
         hts_pkg::SEL_NEXT: sel_idx = next_idx;
         hts_pkg::SEL_SCAN: sel_idx = chk_idx_ff;
         default:           sel_idx = '0;
      endcase
   end

   assign ram_wr_en   = cmd.clr_step | cmd.write;
   assign ram_wr_addr = cmd.clr_step ? clr_ptr_ff : sel_idx;
   assign ram_wr_data = cmd.clr_step ? '0 : {1'b1, key_ff};
   assign ram_rd_en   = cmd.rd_home | cmd.rd_next | scan_issue;
   assign ram_rd_addr = cmd.rd_home ? rem_ff :
                        cmd.rd_next ? next_idx : scan_ptr_ff[IDX_W-1:0];

   hts_ram #(
      .WIDTH(KEY_W + 1),
      .DEPTH(TABLE_SIZE)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // insert looks for a free slot, search for a valid slot holding the key
   assign slot_vld = ram_rd_data[KEY_W];
   assign hit = op_ff ? (slot_vld && (ram_rd_data[KEY_W-1:0] == key_ff)) : !slot_vld;

   assign sts.clr_last  = (clr_ptr_ff == LAST_IDX);
   assign sts.hash_last = hcnt_ff;
   assign sts.search    = op_ff;
   assign sts.hit       = hit;
   assign sts.scan_hit  = chk_vld_ff && hit;
   assign sts.scan_miss = chk_vld_ff && !hit && (chk_idx_ff == LAST_IDX);

   assign slot_ext = (IDX_W+SLOT_W)'(res_slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
         coll_ff    <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end
         if (cmd.bump && (coll_ff != CNT_MAX)) begin
            coll_ff <= coll_ff + 1'b1;
         end
         if (cmd.scan_init) begin
            chk_vld_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            chk_vld_ff <= scan_issue;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         key_ff  <= req_key;
         hcnt_ff <= 1'b0;
         rem_ff  <= '0;
      end else if (cmd.hash_step) begin
         prod_ff <= PROD_W'(key_ff) * PROD_W'(RECIP);
         hcnt_ff <= 1'b1;
         if (hcnt_ff) begin
            rem_ff <= rem_in;
         end
      end
      if (cmd.scan_init) begin
         scan_ptr_ff <= '0;
      end else if (scan_issue) begin
         scan_ptr_ff <= scan_ptr_ff + 1'b1;
         chk_idx_ff  <= scan_ptr_ff[IDX_W-1:0];
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_status;
         res_slot_ff   <= sel_idx;
      end
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
         rsp_coll_ff   <= coll_ff;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_collision_count = rsp_coll_ff;

endmodule

[design/hts_ctrl.sv]
// ----------------------------------------------------------------------------
// hts_ctrl
// Controller: sequences clear pass, hashing, probes, scan and response.
// ----------------------------------------------------------------------------
module hts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  hts_pkg::sts_type sts,
   output hts_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_HOME_RD,
      ST_HOME_CHK,
      ST_NEXT_CHK,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   hts_pkg::status_type hit_status;
   hts_pkg::status_type miss_status;

   assign hit_status  = sts.search ? hts_pkg::STAT_FOUND : hts_pkg::STAT_STORED;
   assign miss_status = sts.search ? hts_pkg::STAT_MISS  : hts_pkg::STAT_FULL;

   always_comb begin
      cmd        = '0;
      cmd.sel    = hts_pkg::SEL_ZERO;
      cmd.res_status = hts_pkg::STAT_STORED;
      state_in   = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash_step = 1'b1;
            if (sts.hash_last) begin
               state_in = ST_HOME_RD;
            end
         end
         ST_HOME_RD: begin
            cmd.rd_home = 1'b1;
            state_in    = ST_HOME_CHK;
         end
         ST_HOME_CHK: begin
            if (sts.hit) begin
               cmd.write      = !sts.search;
               cmd.set_res    = 1'b1;
               cmd.sel        = hts_pkg::SEL_HOME;
               cmd.res_status = hit_status;
               state_in       = ST_DONE;
            end else if (!sts.search) begin
               cmd.bump    = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = ST_NEXT_CHK;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_NEXT_CHK: begin
            if (sts.hit) begin
               cmd.write      = 1'b1;
               cmd.set_res    = 1'b1;
               cmd.sel        = hts_pkg::SEL_NEXT;
               cmd.res_status = hts_pkg::STAT_STORED;
               state_in       = ST_DONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_hit) begin
               cmd.write      = !sts.search;
               cmd.set_res    = 1'b1;
               cmd.sel        = hts_pkg::SEL_SCAN;
               cmd.res_status = hit_status;
               state_in       = ST_DONE;
            end else if (sts.scan_miss) begin
               cmd.set_res    = 1'b1;
               cmd.sel        = hts_pkg::SEL_ZERO;
               cmd.res_status = miss_status;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/hash_table_insert_search.sv]
// ----------------------------------------------------------------------------
// hash_table_insert_search
// Open-addressing hash table of TABLE_SIZE key slots with insert and search.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel carries one request: opcode (insert or search) and a key.
//   rsp_* channel returns one result per request: status, slot index (low
//   five bits of the slot number) and the saturating collision count.
//   Requests are handled one at a time. Each request goes through the
//   key-modulo unit (reciprocal multiply, then subtract), then probes the
//   slot RAM through its single registered read port: the home slot, the
//   next slot for inserts, and a pipelined scan from slot 0.
//   req_ready goes high again in the same cycle as rsp_valid.
//   After reset the block sweeps the slot RAM, one slot a cycle, clearing all
//   valid marks: req_ready stays low until the sweep is done.
//   A result waits in the output register while rsp_ready is low; the next
//   request is still accepted and processed, and only its final transfer to
//   the output register holds until the waiting result is taken.
// ----------------------------------------------------------------------------
module hash_table_insert_search #(
   parameter int TABLE_SIZE = hts_pkg::DEF_TABLE_SIZE
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [hts_pkg::KEY_W-1:0]    req_key,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [hts_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [hts_pkg::CNT_W-1:0]    rsp_collision_count
);

   hts_pkg::cmd_type cmd;
   hts_pkg::sts_type sts;

   // controller: decides each step from datapath status
   hts_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // datapath: modulo unit, slot RAM, counters and result registers
   hts_dpath #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_opcode),
      .req_key            (req_key),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_collision_count(rsp_collision_count)
   );

   // hold off requests while the clearing sweep runs
   assert property (@(posedge clock) $past(reset) && !reset |-> !req_ready)
      else $error("request accepted during clearing sweep");

   // one request in flight: accepting drops ready in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while one is in flight");

   // full table and not found report slot zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == hts_pkg::STAT_FULL || rsp_status == hts_pkg::STAT_MISS)
      |-> rsp_slot_index == '0)
      else $error("miss result carries a nonzero slot");

endmodule

[tb/hash_table_insert_search_tb.sv]
// ----------------------------------------------------------------------------
// hash_table_insert_search_tb
// Self-checking bench for the hash table block. A queue-fed driver offers
// insert and search requests and a shadow table predicts every result. A
// clocked monitor checks each result field by field, with random stalls on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_table_insert_search_tb;

   localparam int          KEY_W      = hts_pkg::KEY_W;
   localparam int          SLOT_W     = hts_pkg::SLOT_W;
   localparam int          CNT_W      = hts_pkg::CNT_W;
   localparam int unsigned TBL        = hts_pkg::DEF_TABLE_SIZE;
   localparam int          N_RANDOM   = 950;
   localparam int          HOLD_AT    = 200;   // result count that starts the hold-off
   localparam int          HOLD_LEN   = 400;   // receiver hold-off length in cycles
   localparam int          STUCK_MAX  = 4000;  // cycles without any handshake
   localparam int          DRAIN      = TBL + 40;

   typedef struct {
      hts_pkg::opcode_type op;
      logic [KEY_W-1:0]    key;
      int unsigned         gap;   // idle cycles before this request is offered
   } table_req_type;

   typedef struct {
      hts_pkg::status_type status;
      logic [SLOT_W-1:0]   slot;
      logic [CNT_W-1:0]    count;
   } table_result_type;

   // DUT connections; every input starts at a known value
   logic                 clock               = 1'b0;
   logic                 reset               = 1'b1;
   logic                 req_valid           = 1'b0;
   logic                 req_ready;
   logic                 req_opcode          = 1'b0;
   logic [KEY_W-1:0]     req_key             = '0;
   logic                 rsp_valid;
   logic                 rsp_ready           = 1'b0;
   logic [1:0]           rsp_status;
   logic [SLOT_W-1:0]    rsp_slot_index;
   logic [CNT_W-1:0]     rsp_collision_count;

   // Shadow copy of the table
   logic [KEY_W-1:0]     shadow_keys [TBL];
   bit                   shadow_valid [TBL];
   logic [CNT_W-1:0]     shadow_collisions = '0;

   table_req_type        req_backlog[$];    // requests not yet offered
   table_result_type     due_results[$];    // results owed by the block
   logic [KEY_W-1:0]     known_keys[$];     // keys queued for insert so far, for hits and duplicates

   int                   err_cnt   = 0;
   int                   n_results = 0;
   int                   tx_hold   = 0;
   int                   rx_wait   = 0;
   bit                   rx_quiet  = 1'b0;
   int                   stuck     = 0;

   hash_table_insert_search i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_key             (req_key),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_collision_count (rsp_collision_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Shadow table: apply one request and return the result it must produce.
   // Insert goes home, then home+1 (wrapping), then the first free slot from 0.
   // Search checks home, then scans from 0 for the first valid match.
   // -------------------------------------------------------------------------
   function automatic table_result_type apply_request(hts_pkg::opcode_type op,
                                                      logic [KEY_W-1:0] key);
      table_result_type r;
      int unsigned      home;
      int unsigned      nxt;
      int unsigned      dest;
      bit               placed;
      int               i;
      home     = key % TBL;
      r.status = (op == hts_pkg::OP_INSERT) ? hts_pkg::STAT_FULL : hts_pkg::STAT_MISS;
      r.slot   = '0;
      placed   = 1'b0;
      dest     = 0;
      if (op == hts_pkg::OP_INSERT) begin
         if (!shadow_valid[home]) begin
            dest   = home;
            placed = 1'b1;
         end else begin
            // home taken: count a collision, saturating
            if (shadow_collisions != {CNT_W{1'b1}})
               shadow_collisions = shadow_collisions + 1'b1;
            nxt = (home + 1 >= TBL) ? 0 : home + 1;
            if (!shadow_valid[nxt]) begin
               dest   = nxt;
               placed = 1'b1;
            end else begin
               for (i = 0; i < TBL && !placed; i++) begin
                  if (!shadow_valid[i]) begin
                     dest   = i;
                     placed = 1'b1;
                  end
               end
            end
         end
         if (placed) begin
            shadow_keys[dest]  = key;
            shadow_valid[dest] = 1'b1;
            r.status           = hts_pkg::STAT_STORED;
            r.slot             = dest[SLOT_W-1:0];
         end
      end else begin
         if (shadow_valid[home] && shadow_keys[home] == key) begin
            r.status = hts_pkg::STAT_FOUND;
            r.slot   = home[SLOT_W-1:0];
         end else begin
            for (i = 0; i < TBL && r.status != hts_pkg::STAT_FOUND; i++) begin
               if (shadow_valid[i] && shadow_keys[i] == key) begin
                  r.status = hts_pkg::STAT_FOUND;
                  r.slot   = i[SLOT_W-1:0];
               end
            end
         end
      end
      r.count = shadow_collisions;
      return r;
   endfunction

   task automatic flag_mismatch(string what, longint got, longint want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      err_cnt++;
   endtask

   task automatic queue_request(hts_pkg::opcode_type op, logic [KEY_W-1:0] key,
                                int unsigned gap);
      table_req_type t;
      t.op  = op;
      t.key = key;
      t.gap = gap;
      req_backlog.push_back(t);
      if (op == hts_pkg::OP_INSERT)
         known_keys.push_back(key);
   endtask

   // -------------------------------------------------------------------------
   // Request driver: hold the payload while stalled, predict on acceptance,
   // then idle for the next request's gap or offer it at once.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      table_req_type nxt_req;
      bit            offer;
      if (reset) begin
         req_valid <= 1'b0;
         tx_hold   = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            // request accepted at this edge: record what it owes
            due_results.push_back(apply_request(hts_pkg::opcode_type'(req_opcode),
                                                req_key));
            if (req_backlog.size() != 0)
               tx_hold = req_backlog[0].gap;
         end
         offer = 1'b0;
         if (tx_hold != 0)
            tx_hold = tx_hold - 1;
         else if (req_backlog.size() != 0)
            offer = 1'b1;
         if (offer) begin
            nxt_req = req_backlog.pop_front();
            req_valid  <= 1'b1;
            req_opcode <= nxt_req.op;
            req_key    <= nxt_req.key;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor: check against the oldest owed result, then draw the
   // stall before the next one. Once, hold off long enough that the block
   // backs up and stops taking requests.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      table_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               flag_mismatch("result with no request pending", rsp_status, 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch("status", rsp_status, want.status);
               if (rsp_slot_index !== want.slot)
                  flag_mismatch("slot_index", rsp_slot_index, want.slot);
               if (rsp_collision_count !== want.count)
                  flag_mismatch("collision_count", rsp_collision_count, want.count);
            end
            n_results++;
            // alternate stretches with and without stalls
            if (n_results % 64 == 0)
               rx_quiet = ($urandom_range(0, 2) == 0);
            if (n_results == HOLD_AT)
               rx_wait = HOLD_LEN;
            else
               rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
         end else if (rx_wait != 0) begin
            rx_wait = rx_wait - 1;
         end
         rsp_ready <= (rx_wait == 0);
      end
   end

   // Watchdog: end the run if no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck <= 0;
      end else if (stuck >= STUCK_MAX) begin
         $display("hash_table_insert_search_tb: errors");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int                  n;
      int                  pick;
      int unsigned         gap;
      bit                  tx_quiet;
      hts_pkg::opcode_type op;
      logic [KEY_W-1:0]    key;
      logic [KEY_W-1:0]    base;
      logic [4:0]          low5;

      // Directed part
      queue_request(hts_pkg::OP_SEARCH, 31'd0, 0);            // search an empty table
      queue_request(hts_pkg::OP_INSERT, 31'd0, 0);            // home slot free
      queue_request(hts_pkg::OP_INSERT, 31'd32, 1);           // home taken, next free
      queue_request(hts_pkg::OP_INSERT, 31'd64, 0);           // home and next taken, scan
      queue_request(hts_pkg::OP_INSERT, 31'd31, 3);           // last slot
      queue_request(hts_pkg::OP_INSERT, 31'd63, 0);           // next wraps to slot 0
      queue_request(hts_pkg::OP_INSERT, 31'h7FFF_FFFF, 0);    // largest key
      queue_request(hts_pkg::OP_INSERT, 31'h7FFF_FFE1, 2);
      queue_request(hts_pkg::OP_SEARCH, 31'd0, 0);            // hit in home slot
      queue_request(hts_pkg::OP_SEARCH, 31'd32, 0);           // hit found by scan
      queue_request(hts_pkg::OP_SEARCH, 31'h7FFF_FFFF, 5);
      queue_request(hts_pkg::OP_SEARCH, 31'd5, 0);            // home holds another key: miss
      queue_request(hts_pkg::OP_INSERT, 31'd0, 0);            // duplicate insert
      queue_request(hts_pkg::OP_SEARCH, 31'd0, 0);            // first match wins
      queue_request(hts_pkg::OP_INSERT, 31'd6, 9);
      queue_request(hts_pkg::OP_INSERT, 31'h2AAA_AAAA, 0);    // alternating bit patterns
      queue_request(hts_pkg::OP_INSERT, 31'h5555_5555, 0);
      queue_request(hts_pkg::OP_SEARCH, 31'h2AAA_AAAA, 0);
      queue_request(hts_pkg::OP_SEARCH, 31'h5555_5555, 4);
      queue_request(hts_pkg::OP_SEARCH, 31'h7FFF_FFFE, 0);    // miss on a large key

      // Random part: the table fills, then inserts hit the full case
      tx_quiet = 1'b0;
      for (n = 0; n < N_RANDOM; n++) begin
         if (n % 40 == 0)
            tx_quiet = ($urandom_range(0, 3) == 0);
         gap  = tx_quiet ? 0 : $urandom_range(0, 9);
         op   = ($urandom_range(0, 2) == 0) ? hts_pkg::OP_INSERT : hts_pkg::OP_SEARCH;
         pick = $urandom_range(0, 9);
         base = known_keys[$urandom_range(0, known_keys.size() - 1)];
         if (pick < 4) begin
            // reuse a stored key: search hit or duplicate insert
            key = base;
         end else if (pick < 7) begin
            // fresh key aimed at an occupied home slot or its neighbor
            low5 = base[4:0] + 5'($urandom_range(0, 1));
            key  = {26'($urandom()), low5};
         end else begin
            key = 31'($urandom());
         end
         queue_request(op, key, gap);
      end

      // Release reset
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Drain: every request sent, every result back, then a quiet margin
      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (due_results.size() != 0)
         flag_mismatch("results never returned", 0, due_results.size());

      if (err_cnt == 0) begin
         $display("hash_table_insert_search_tb: clean");
      end else begin
         $display("hash_table_insert_search_tb: errors");
      end
      $finish;
   end

endmodule
